### rtl/core/ensemble_rank_histogram_macros.svh
// Assertion macros for the ensemble rank histogram block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef ENSEMBLE_RANK_HISTOGRAM_MACROS_SVH
`define ENSEMBLE_RANK_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ERH_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ERH_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/core/erh_pkg.sv
// Shared types, codes and constants of the ensemble rank histogram block.
// Used by every module of the block except erh_ram; depends on nothing.
package erh_pkg;

    localparam int MAX_MEMBERS = 64;
    localparam int NBINS = MAX_MEMBERS + 1;
    localparam int BIN_W = $clog2(NBINS);
    localparam int CNT_W = 7;
    localparam int PICK_W = 16;
    localparam int TOL_W = 16;
    localparam int VAL_W = 32;
    localparam int COUNT_W = 32;
    localparam int CFG_W = 16;
    localparam int OPQ_DEPTH = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] EXPECTED_RESET = CNT_W'(64);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    localparam logic [1:0] CMD_MEMBER = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic KIND_RANK = 1'b0;
    localparam logic KIND_BIN = 1'b1;

    localparam logic CFG_EXPECTED = 1'b0;
    localparam logic CFG_TOLERANCE = 1'b1;

    typedef enum logic [1:0] {
        OP_RANK,
        OP_READ,
        OP_CLEAR
    } t_op_code;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [VAL_W-1:0] obs_value;
        logic signed [VAL_W-1:0] member_value;
        logic                    member_missing;
        logic                    last_member;
        logic [PICK_W-1:0]       random_pick;
        logic [CNT_W-1:0]        bin_index;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [CNT_W-1:0]   valid_count;
        logic [CNT_W-1:0]   rank;
        logic               rank_ok;
        logic [COUNT_W-1:0] bin_count;
    } t_out_item;

    typedef struct packed {
        t_op_code         code;
        logic [CNT_W-1:0] valid_count;
        logic [CNT_W-1:0] rank;
        logic             rank_ok;
        logic [BIN_W-1:0] bin;
        logic             bin_ok;
    } t_op;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

### rtl/core/erh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the histogram bins.
module erh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/erh_front.sv
// Front end: accepts requests, classifies members and keeps the per-observation counters.
// Emits rank, read and clear operations toward the back end; uses erh_pkg.
module erh_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  erh_pkg::t_in_item            i_item,
    input  logic [erh_pkg::CNT_W-1:0]    i_expected,
    input  logic [erh_pkg::TOL_W-1:0]    i_tolerance,
    output logic                         o_op_push,
    output erh_pkg::t_op                 o_op,
    input  logic                         i_op_full
);

    localparam int PROD_W = erh_pkg::PICK_W + erh_pkg::CNT_W + 1;

    logic                          r_s1_valid;
    erh_pkg::t_in_item             r_s1_item;
    logic                          r_s1_tie;
    logic                          r_s1_below;
    logic [erh_pkg::CNT_W-1:0]     r_valid_cnt;
    logic [erh_pkg::CNT_W-1:0]     r_below_cnt;
    logic [erh_pkg::CNT_W-1:0]     r_tie_cnt;

    logic [erh_pkg::VAL_W:0]       diff;
    logic [erh_pkg::VAL_W:0]       abs_diff;
    logic                          in_tie;
    logic                          in_below;
    logic                          accept;
    logic                          s1_member;
    logic                          s1_needs_push;
    logic                          s1_go;
    logic                          counted;
    logic [erh_pkg::CNT_W-1:0]     n_valid_cnt;
    logic [erh_pkg::CNT_W-1:0]     n_below_cnt;
    logic [erh_pkg::CNT_W-1:0]     n_tie_cnt;
    logic [erh_pkg::CNT_W:0]       tie_plus;
    logic [PROD_W-1:0]             prod;
    logic [erh_pkg::CNT_W+1:0]     rank_sum;
    logic [erh_pkg::CNT_W-1:0]     rank;

    assign diff = {i_item.member_value[erh_pkg::VAL_W-1], i_item.member_value}
                - {i_item.obs_value[erh_pkg::VAL_W-1], i_item.obs_value};
    assign abs_diff = diff[erh_pkg::VAL_W] ? (~diff + 1'b1) : diff;
    assign in_tie = abs_diff <= (erh_pkg::VAL_W + 1)'(i_tolerance);
    assign in_below = $signed(i_item.member_value) < $signed(i_item.obs_value);

    assign s1_member = r_s1_item.cmd == erh_pkg::CMD_MEMBER;
    always_comb begin
        case (r_s1_item.cmd)
            erh_pkg::CMD_MEMBER: s1_needs_push = r_s1_item.last_member;
            erh_pkg::CMD_READ:   s1_needs_push = 1'b1;
            erh_pkg::CMD_CLEAR:  s1_needs_push = 1'b1;
            default:             s1_needs_push = 1'b0;
        endcase
    end
    assign s1_go = r_s1_valid && (!s1_needs_push || !i_op_full);
    assign o_full = r_s1_valid && !s1_go;
    assign accept = i_push && !o_full;

    assign counted = s1_member && !r_s1_item.member_missing;
    assign n_valid_cnt = counted ? erh_pkg::sat_inc(r_valid_cnt) : r_valid_cnt;
    assign n_tie_cnt = (counted && r_s1_tie) ? erh_pkg::sat_inc(r_tie_cnt) : r_tie_cnt;
    assign n_below_cnt = (counted && !r_s1_tie && r_s1_below)
                       ? erh_pkg::sat_inc(r_below_cnt) : r_below_cnt;

    assign tie_plus = {1'b0, n_tie_cnt} + 1'b1;
    assign prod = PROD_W'(r_s1_item.random_pick) * PROD_W'(tie_plus);
    assign rank_sum = (erh_pkg::CNT_W + 2)'(n_below_cnt) + 1'b1
                    + (erh_pkg::CNT_W + 2)'(prod[PROD_W-1:erh_pkg::PICK_W]);
    assign rank = (rank_sum > (erh_pkg::CNT_W + 2)'(erh_pkg::CNT_MAX))
                ? erh_pkg::CNT_MAX : rank_sum[erh_pkg::CNT_W-1:0];

    always_comb begin
        o_op = '0;
        case (r_s1_item.cmd)
            erh_pkg::CMD_MEMBER: begin
                o_op.code = erh_pkg::OP_RANK;
                o_op.valid_count = n_valid_cnt;
                o_op.rank = rank;
                o_op.rank_ok = (n_valid_cnt == i_expected)
                            && (32'(n_valid_cnt) <= erh_pkg::MAX_MEMBERS);
                o_op.bin = erh_pkg::BIN_W'(rank - 1'b1);
                o_op.bin_ok = 32'(rank) <= erh_pkg::NBINS;
            end
            erh_pkg::CMD_READ: begin
                o_op.code = erh_pkg::OP_READ;
                o_op.bin = erh_pkg::BIN_W'(r_s1_item.bin_index);
                o_op.bin_ok = 32'(r_s1_item.bin_index) < erh_pkg::NBINS;
            end
            default: begin
                o_op.code = erh_pkg::OP_CLEAR;
            end
        endcase
    end
    assign o_op_push = s1_go && s1_needs_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_valid_cnt <= '0;
            r_below_cnt <= '0;
            r_tie_cnt <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go && s1_member) begin
                if (r_s1_item.last_member) begin
                    r_valid_cnt <= '0;
                    r_below_cnt <= '0;
                    r_tie_cnt <= '0;
                end else begin
                    r_valid_cnt <= n_valid_cnt;
                    r_below_cnt <= n_below_cnt;
                    r_tie_cnt <= n_tie_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_item;
            r_s1_tie <= in_tie;
            r_s1_below <= in_below;
        end
    end

endmodule

### rtl/core/erh_opq.sv
// Short operation queue between the front end and the back end.
// Holds erh_pkg::t_op entries in registers.
module erh_opq (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  erh_pkg::t_op i_op,
    output logic         o_full,
    output logic         o_valid,
    output erh_pkg::t_op o_op,
    input  logic         i_pop
);

    localparam int PTR_W = $clog2(erh_pkg::OPQ_DEPTH);
    localparam int CNT_W = $clog2(erh_pkg::OPQ_DEPTH + 1);

    erh_pkg::t_op     r_entry [erh_pkg::OPQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full = r_count == CNT_W'(erh_pkg::OPQ_DEPTH);
    assign o_valid = r_count != '0;
    assign o_op = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(erh_pkg::OPQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_op;
        end
    end

endmodule

### rtl/core/erh_back.sv
// Back end: updates and reads the histogram bins and queues the results.
// Uses erh_pkg and one erh_ram instance for the bins.
module erh_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_valid,
    input  erh_pkg::t_op       i_op,
    output logic               o_op_pop,
    output logic               o_empty,
    output erh_pkg::t_out_item o_res,
    input  logic               i_pop
);

    logic                              r_b_valid;
    erh_pkg::t_op                      r_b_op;
    logic [erh_pkg::NBINS-1:0]         r_bin_valid;
    logic                              r_fwd_valid;
    logic [erh_pkg::BIN_W-1:0]         r_fwd_addr;
    logic [erh_pkg::COUNT_W-1:0]       r_fwd_data;
    erh_pkg::t_out_item                r_res [2];
    logic [1:0]                        r_res_cnt;

    logic [erh_pkg::COUNT_W-1:0]       rdata;
    logic [erh_pkg::COUNT_W-1:0]       cur;
    logic [erh_pkg::COUNT_W-1:0]       wdata;
    logic                              needs_out;
    logic                              res_pop;
    logic                              res_space;
    logic                              b_retire;
    logic                              advance;
    logic                              ram_re;
    logic                              b_write;
    logic                              res_push;
    logic                              res_to_head;
    erh_pkg::t_out_item                res_item;

    assign res_pop = i_pop && (r_res_cnt != 2'd0);
    assign res_space = (r_res_cnt != 2'd2) || res_pop;
    assign needs_out = (r_b_op.code == erh_pkg::OP_RANK) || (r_b_op.code == erh_pkg::OP_READ);
    assign b_retire = r_b_valid && (!needs_out || res_space);
    assign advance = !r_b_valid || b_retire;
    assign o_op_pop = advance && i_op_valid;
    assign ram_re = o_op_pop && i_op.bin_ok && (i_op.code != erh_pkg::OP_CLEAR);

    erh_ram #(
        .WIDTH(erh_pkg::COUNT_W),
        .DEPTH(erh_pkg::NBINS)
    ) u_bins (
        .i_clk  (i_clk),
        .i_we   (b_write),
        .i_waddr(r_b_op.bin),
        .i_wdata(wdata),
        .i_re   (ram_re),
        .i_raddr(i_op.bin),
        .o_rdata(rdata)
    );

    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_b_op.bin)) begin
            cur = r_fwd_data;
        end else if (r_b_op.bin_ok && r_bin_valid[r_b_op.bin]) begin
            cur = rdata;
        end else begin
            cur = '0;
        end
    end
    assign wdata = (cur == '1) ? cur : cur + 1'b1;
    assign b_write = b_retire && (r_b_op.code == erh_pkg::OP_RANK)
                  && r_b_op.rank_ok && r_b_op.bin_ok;

    always_comb begin
        res_item = '0;
        case (r_b_op.code)
            erh_pkg::OP_RANK: begin
                res_item.kind = erh_pkg::KIND_RANK;
                res_item.valid_count = r_b_op.valid_count;
                res_item.rank = r_b_op.rank;
                res_item.rank_ok = r_b_op.rank_ok;
            end
            erh_pkg::OP_READ: begin
                res_item.kind = erh_pkg::KIND_BIN;
                res_item.bin_count = r_b_op.bin_ok ? cur : '0;
            end
            default: begin
                res_item = '0;
            end
        endcase
    end
    assign res_push = b_retire && needs_out;
    assign res_to_head = res_push
                      && ((r_res_cnt == 2'd0) || ((r_res_cnt == 2'd1) && res_pop));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_bin_valid <= '0;
            r_fwd_valid <= 1'b0;
            r_res_cnt <= 2'd0;
        end else begin
            if (advance) begin
                r_b_valid <= i_op_valid;
            end
            if (b_retire && (r_b_op.code == erh_pkg::OP_CLEAR)) begin
                r_bin_valid <= '0;
                r_fwd_valid <= 1'b0;
            end else if (b_write) begin
                r_bin_valid[r_b_op.bin] <= 1'b1;
                r_fwd_valid <= 1'b1;
            end
            if (res_push && !res_pop) begin
                r_res_cnt <= r_res_cnt + 1'b1;
            end else if (res_pop && !res_push) begin
                r_res_cnt <= r_res_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_op_valid) begin
            r_b_op <= i_op;
        end
        if (b_write) begin
            r_fwd_addr <= r_b_op.bin;
            r_fwd_data <= wdata;
        end
        if (res_to_head) begin
            r_res[0] <= res_item;
        end else if (res_pop) begin
            r_res[0] <= r_res[1];
        end
        if (res_push && !res_to_head) begin
            r_res[1] <= res_item;
        end
    end

    assign o_empty = r_res_cnt == 2'd0;
    assign o_res = r_res[0];

endmodule

### rtl/core/ensemble_rank_histogram.sv
// Top level of the ensemble rank histogram block: configuration registers and wiring.
// Uses erh_pkg, erh_front, erh_opq, erh_back and the assertion macro header.
//
// Channel   Direction  Handshake             Payload
// request   in         i_push / o_full       i_item (erh_pkg::t_in_item)
// result    out        o_empty / i_pop       o_res (erh_pkg::t_out_item)
// config    in         i_cfg_we              i_cfg_index, i_cfg_data
//
// One request is taken every cycle while results are popped as they appear.
// A result passes through classify and count, the queue and bin access, each registered, then the result buffer.
// Back-to-back updates of one bin are forwarded around the bin RAM's read latency.
// A clear drops the per-bin valid flags, so no sweep follows reset.
// When results are not popped, the op queue fills and o_full rises.
`include "ensemble_rank_histogram_macros.svh"

module ensemble_rank_histogram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  erh_pkg::t_in_item           i_item,
    output logic                        o_empty,
    input  logic                        i_pop,
    output erh_pkg::t_out_item          o_res,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [erh_pkg::CFG_W-1:0]   i_cfg_data
);

    logic [erh_pkg::CNT_W-1:0] r_expected;
    logic [erh_pkg::TOL_W-1:0] r_tolerance;

    logic         q_push;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    erh_pkg::t_op front_op;
    erh_pkg::t_op q_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= erh_pkg::EXPECTED_RESET;
            r_tolerance <= erh_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                erh_pkg::CFG_EXPECTED:  r_expected <= i_cfg_data[erh_pkg::CNT_W-1:0];
                erh_pkg::CFG_TOLERANCE: r_tolerance <= i_cfg_data[erh_pkg::TOL_W-1:0];
                default: begin
                    r_expected <= r_expected;
                end
            endcase
        end
    end

    erh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_item     (i_item),
        .i_expected (r_expected),
        .i_tolerance(r_tolerance),
        .o_op_push  (q_push),
        .o_op       (front_op),
        .i_op_full  (q_full)
    );

    erh_opq u_opq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_op   (front_op),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_op   (q_op),
        .i_pop  (q_pop)
    );

    erh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op_valid(q_valid),
        .i_op      (q_op),
        .o_op_pop  (q_pop),
        .o_empty   (o_empty),
        .o_res     (o_res),
        .i_pop     (i_pop)
    );

    `ERH_ASSERT_SAME(a_opq_no_overflow, q_push, !q_full, "Op queue written while full.")
    `ERH_ASSERT_SAME(a_rank_ok_range,
        !o_empty && (o_res.kind == erh_pkg::KIND_RANK) && o_res.rank_ok,
        (o_res.rank != '0) && (32'(o_res.rank) <= erh_pkg::NBINS)
            && (o_res.valid_count == r_expected),
        "Valid rank result out of range or count mismatch.")
    `ERH_ASSERT_SAME(a_readout_clean,
        !o_empty && (o_res.kind == erh_pkg::KIND_BIN),
        (o_res.valid_count == '0) && (o_res.rank == '0) && !o_res.rank_ok,
        "Bin readout carries rank fields.")
    `ERH_ASSERT_NEXT(a_result_held,
        !o_empty && !i_pop,
        !o_empty && $stable(o_res),
        "Waiting result changed or vanished without a pop.")

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Testbench for the ensemble rank histogram block: member streams, bin reads and clears.
// Results are checked against an in-bench model of the counters and the histogram.
// Depends on erh_pkg and the ensemble_rank_histogram top level.
module testbench;
    import erh_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_push = 1'b0;
    logic             o_full;
    t_in_item         i_item = '0;
    logic             o_empty;
    logic             i_pop = 1'b0;
    t_out_item        o_res;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_index = CFG_EXPECTED;
    logic [CFG_W-1:0] i_cfg_data = '0;

    logic [CNT_W-1:0]   m_valid;
    logic [CNT_W-1:0]   m_below;
    logic [CNT_W-1:0]   m_tie;
    logic [COUNT_W-1:0] m_hist [NBINS];
    logic [CNT_W-1:0]   m_expected;
    logic [TOL_W-1:0]   m_tolerance;
    t_out_item          owed_results[$];
    int                 mismatch_count = 0;
    int                 burst_left = 0;

    ensemble_rank_histogram dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_item      (i_item),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s", $time, what);
        end
    endtask

    task automatic reset_model();
        m_valid = '0;
        m_below = '0;
        m_tie = '0;
        m_expected = EXPECTED_RESET;
        m_tolerance = TOL_RESET;
        foreach (m_hist[b]) m_hist[b] = '0;
    endtask

    task automatic apply_to_histogram(input t_in_item req);
        longint      diff;
        longint      mag;
        int unsigned rank_val;
        int unsigned pick;
        int unsigned ties;
        int unsigned bin_sel;
        logic        ok;
        t_out_item   res;
        res = '0;
        case (req.cmd)
            CMD_READ: begin
                res.kind = KIND_BIN;
                res.bin_count = (req.bin_index < NBINS) ? m_hist[req.bin_index] : '0;
                owed_results.push_back(res);
            end
            CMD_CLEAR: begin
                foreach (m_hist[b]) m_hist[b] = '0;
            end
            CMD_MEMBER: begin
                if (!req.member_missing) begin
                    diff = longint'($signed(req.member_value))
                         - longint'($signed(req.obs_value));
                    mag = (diff < 0) ? -diff : diff;
                    if (m_valid != CNT_MAX) m_valid++;
                    if (mag <= longint'(m_tolerance)) begin
                        if (m_tie != CNT_MAX) m_tie++;
                    end else if (diff < 0) begin
                        if (m_below != CNT_MAX) m_below++;
                    end
                end
                if (req.last_member) begin
                    rank_val = 32'(m_below) + 1;
                    if (m_tie != 0) begin
                        pick = 32'(req.random_pick);
                        ties = 32'(m_tie);
                        rank_val += (pick * (ties + 1)) >> 16;
                    end
                    if (rank_val > CNT_MAX) rank_val = CNT_MAX;
                    ok = (m_valid == m_expected) && (m_valid <= MAX_MEMBERS);
                    if (ok) begin
                        bin_sel = rank_val - 1;
                        if (bin_sel < NBINS && m_hist[bin_sel] != '1) begin
                            m_hist[bin_sel]++;
                        end
                    end
                    res.kind = KIND_RANK;
                    res.valid_count = m_valid;
                    res.rank = rank_val[CNT_W-1:0];
                    res.rank_ok = ok;
                    owed_results.push_back(res);
                    m_valid = '0;
                    m_below = '0;
                    m_tie = '0;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        logic      bad;
        if (i_rst_n && !o_empty && i_pop) begin
            if (owed_results.size() == 0) begin
                note_mismatch($sformatf("unrequested result kind %0d rank %0d bin_count %0d",
                                        o_res.kind, o_res.rank, o_res.bin_count));
            end else begin
                want = owed_results.pop_front();
                bad = (o_res.kind !== want.kind) || (o_res.valid_count !== want.valid_count)
                   || (o_res.rank !== want.rank) || (o_res.rank_ok !== want.rank_ok)
                   || (o_res.bin_count !== want.bin_count);
                if (bad) begin
                    note_mismatch($sformatf(
                        "want kind %0d valid %0d rank %0d ok %0d bin %0d, got %0d %0d %0d %0d %0d",
                        want.kind, want.valid_count, want.rank, want.rank_ok, want.bin_count,
                        o_res.kind, o_res.valid_count, o_res.rank, o_res.rank_ok,
                        o_res.bin_count));
                end
            end
        end
    end

    int          pop_style = 0;
    int          pop_hold = 0;
    int unsigned pop_tick = 0;

    always @(posedge i_clk) begin
        if (pop_hold == 0) begin
            pop_style = $urandom_range(0, 3);
            pop_hold = $urandom_range(5, 60);
        end
        pop_hold--;
        pop_tick++;
        case (pop_style)
            0: i_pop <= 1'b1;
            1: i_pop <= ($urandom_range(0, 1) == 1);
            2: i_pop <= ($urandom_range(0, 5) == 0);
            default: i_pop <= (pop_tick[1:0] == 2'b00);
        endcase
    end

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    task automatic send_request(input t_in_item req);
        i_push <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        apply_to_histogram(req);
        pace();
    endtask

    task automatic drain_results();
        i_push <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CNT_W-1:0] members, input logic [TOL_W-1:0] tol);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_EXPECTED;
        i_cfg_data <= {(CFG_W - CNT_W)'($urandom), members};
        @(posedge i_clk);
        m_expected = members;
        i_cfg_index <= CFG_TOLERANCE;
        i_cfg_data <= tol;
        @(posedge i_clk);
        m_tolerance = tol;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_member(input logic [VAL_W-1:0] obs, input logic [VAL_W-1:0] mem,
                               input logic missing, input logic last,
                               input logic [PICK_W-1:0] pick);
        t_in_item req;
        req.cmd = CMD_MEMBER;
        req.obs_value = obs;
        req.member_value = mem;
        req.member_missing = missing;
        req.last_member = last;
        req.random_pick = pick;
        req.bin_index = CNT_W'($urandom);
        send_request(req);
    endtask

    task automatic send_command(input logic [1:0] cmd, input logic [CNT_W-1:0] bin_sel);
        t_in_item req;
        req.cmd = cmd;
        req.obs_value = $urandom;
        req.member_value = $urandom;
        req.member_missing = 1'($urandom);
        req.last_member = 1'($urandom);
        req.random_pick = PICK_W'($urandom);
        req.bin_index = bin_sel;
        send_request(req);
    endtask

    function automatic logic [VAL_W-1:0] near_value(input logic [VAL_W-1:0] obs);
        longint      off;
        int unsigned tol;
        tol = 32'(m_tolerance);
        case ($urandom_range(0, 4))
            0: off = longint'($urandom_range(0, tol));
            1: off = longint'(tol);
            2: off = longint'(tol) + 1;
            3: off = longint'($urandom_range(tol + 1, tol + 200000));
            default: return $urandom;
        endcase
        if ($urandom_range(0, 1) == 1) off = -off;
        return obs + VAL_W'(off);
    endfunction

    function automatic logic [PICK_W-1:0] random_pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return PICK_W'($urandom);
        endcase
    endfunction

    task automatic send_observation(input int target, output int count);
        logic [VAL_W-1:0] obs;
        logic             end_missing;
        obs = ($urandom_range(0, 3) == 0) ? VAL_W'($signed($urandom_range(0, 20)) - 10) << 16
                                          : VAL_W'($urandom);
        end_missing = (target == 0) || ($urandom_range(0, 4) == 0);
        count = 0;
        for (int k = 0; k < target; k++) begin
            if ($urandom_range(0, 5) == 0) begin
                send_member(obs, $urandom, 1'b1, 1'b0, PICK_W'($urandom));
                count++;
            end
            send_member(obs, near_value(obs), 1'b0, (k == target - 1) && !end_missing,
                        random_pick_word());
            count++;
        end
        if (end_missing) begin
            send_member(obs, $urandom, 1'b1, 1'b1, random_pick_word());
            count++;
        end
    endtask

    task automatic test_reset_defaults();
        send_member(32'sd0, 32'sd1, 1'b0, 1'b0, 16'h0000);
        send_member(32'sd0, 32'sd2, 1'b0, 1'b0, 16'h0000);
        send_member(32'sd0, -32'sd2, 1'b0, 1'b0, 16'h0000);
        send_member(32'sd0, 32'sd0, 1'b0, 1'b1, 16'h8000);
        send_command(CMD_READ, 7'd2);
    endtask

    task automatic test_directed_ranks();
        drain_results();
        write_config(7'd3, 16'd0);
        send_member(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 16'h0000);
        send_member(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'h0000);
        send_member(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 16'hFFFF);
        send_member(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'h1234);
        send_member(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 16'h1234);
        send_member(32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'h1234);
        send_member(-(32'sd5 << 16), -(32'sd6 << 16), 1'b0, 1'b0, 16'h0000);
        send_member(-(32'sd5 << 16), -(32'sd7 << 16), 1'b0, 1'b0, 16'h0000);
        send_member(-(32'sd5 << 16), 32'sd1 << 16, 1'b0, 1'b1, 16'h0000);
        send_command(CMD_READ, 7'd3);
        send_command(CMD_READ, 7'd2);
        send_command(CMD_READ, 7'd64);
        send_command(CMD_READ, 7'd65);
        send_command(CMD_READ, 7'd127);
        send_command(CMD_CLEAR, 7'd3);
        send_command(CMD_READ, 7'd3);
        send_command(CMD_UNUSED, 7'd0);
        send_command(CMD_READ, 7'd0);
    endtask

    task automatic test_special_expected();
        int count;
        drain_results();
        write_config(7'd0, 16'h8000);
        send_member(32'sd0, 32'sd0, 1'b1, 1'b0, 16'h0000);
        send_member(32'sd0, 32'sd0, 1'b1, 1'b0, 16'h0000);
        send_member(32'sd0, 32'sd0, 1'b1, 1'b1, 16'hFFFF);
        send_command(CMD_READ, 7'd0);
        drain_results();
        write_config(7'd65, 16'd5);
        send_observation(65, count);
        send_command(CMD_READ, 7'd64);
        drain_results();
        write_config(7'd127, 16'd7);
        send_observation(2, count);
    endtask

    task automatic test_counter_saturation();
        drain_results();
        write_config(7'd64, 16'd0);
        for (int k = 0; k < 130; k++) begin
            send_member(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, k == 129, 16'hFFFF);
        end
        drain_results();
        write_config(7'd64, 16'hFFFF);
        for (int k = 0; k < 130; k++) begin
            send_member(32'h0001_0000, 32'h0001_0000, 1'b0, k == 129, 16'hFFFF);
        end
        send_command(CMD_READ, 7'd126);
    endtask

    task automatic test_random_streams();
        int unsigned phase_members [6] = '{1, 4, 8, 3, 64, 2};
        int unsigned phase_tol [6] = '{0, 1, 65535, 300, 16, 40000};
        int          sent;
        int          count;
        int          target;
        int unsigned choice;
        for (int p = 0; p < 6; p++) begin
            drain_results();
            write_config(CNT_W'(phase_members[p]), TOL_W'(phase_tol[p]));
            sent = 0;
            while (sent < 70) begin
                choice = $urandom_range(0, 99);
                if (choice < 75) begin
                    if ($urandom_range(0, 9) < 7) begin
                        target = int'(m_expected);
                    end else begin
                        target = $urandom_range(0, m_expected + 2);
                    end
                    send_observation(target, count);
                    sent += count;
                end else if (choice < 92) begin
                    send_command(CMD_READ, CNT_W'(($urandom_range(0, 3) == 0)
                                                  ? $urandom_range(0, 127)
                                                  : $urandom_range(0, 64)));
                    sent++;
                end else if (choice < 95) begin
                    send_command(CMD_CLEAR, CNT_W'($urandom));
                    sent++;
                end else begin
                    send_command(CMD_UNUSED, CNT_W'($urandom));
                end
            end
        end
    endtask

    initial begin
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_ranks();
        test_special_expected();
        test_counter_saturation();
        test_random_streams();
        drain_results();
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### ensemble_rank_histogram.f
+incdir+rtl/core
rtl/core/erh_pkg.sv
rtl/core/erh_ram.sv
rtl/core/erh_front.sv
rtl/core/erh_opq.sv
rtl/core/erh_back.sv
rtl/core/ensemble_rank_histogram.sv
test/testbench.sv
